>>> hw/rtl/slfr_pkg.sv
// slfr_pkg: shared types and constants for the sync/length frame receiver
// used by every module under hw/rtl; depends on nothing else

package slfr_pkg;

  localparam int FRAME_CAP_DEF = 256;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0]  SYNC_FIRST   = 8'h39;
  localparam logic [7:0]  SYNC_SECOND  = 8'h50;
  localparam int          LEN_EXTRA    = 6;
  localparam int          HEADER_BYTES = 4;
  localparam logic [8:0]  MIN_LEN_RST  = 9'd6;

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_COLLECT = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_RESYNC  = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;

  typedef enum logic {
    OP_RECV,
    OP_READ
  } op_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] frame_length;
    logic [7:0] read_data;
    logic [8:0] fill_level;
  } out_item_t;

  // classified item as it sits in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
    logic       is_sync1;
    logic       is_sync2;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

>>> hw/rtl/sync_length_frame_receiver.sv
// an item passes the front register and the queue, then the back end states:
//   B_IDLE, B_WRITE, B_CHECK, B_FIN for a buffered byte; B_IDLE, B_RDWAIT, B_FIN for a read;
//   B_IDLE, B_FIN for a byte taken while hunting; B_FIN waits for a free result register
// the back end makes one pass per item and pops the next only back in B_IDLE; a resync scans
//   pairs one per cycle up to the first match, then shifts one byte per cycle
// rst (synchronous): buffer empty, min_len = 6, no result pending; contents kept

module sync_length_frame_receiver #(
  parameter int FRAME_CAP = slfr_pkg::FRAME_CAP_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  slfr_pkg::in_item_t  rx_item,
  output logic                res_valid,
  input  logic                res_stall,
  output slfr_pkg::out_item_t res_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [8:0]          cfg_data
);

  slfr_pkg::q_stat_t q_stat;
  slfr_pkg::q_item_t push_item;
  slfr_pkg::q_item_t q_head;
  logic              push;
  logic              q_pop;

  // the register is taken in any cycle
  assign cfg_ready = 1'b1;

  slfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_item   (rx_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  slfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  slfr_back #(
    .FRAME_CAP (FRAME_CAP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

>>> hw/rtl/slfr_front.sv
// slfr_front: input register that accepts items and classifies them
// depends on slfr_pkg; feeds slfr_queue

module slfr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  slfr_pkg::in_item_t  rx_item,
  input  slfr_pkg::q_stat_t   q_stat,
  output logic                push,
  output slfr_pkg::q_item_t   push_item
);

  logic              f_vld;
  slfr_pkg::q_item_t f_item;

  assign push      = f_vld && !q_stat.full;
  assign rx_stall  = f_vld && q_stat.full;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
    if (rx_valid && !rx_stall) begin
      f_item.op         <= rx_item.action ? slfr_pkg::OP_READ : slfr_pkg::OP_RECV;
      f_item.rx_byte    <= rx_item.rx_byte;
      f_item.read_index <= rx_item.read_index;
      f_item.is_sync1   <= (rx_item.rx_byte == slfr_pkg::SYNC_FIRST);
      f_item.is_sync2   <= (rx_item.rx_byte == slfr_pkg::SYNC_SECOND);
    end
  end

endmodule

>>> hw/rtl/slfr_queue.sv
// slfr_queue: short fifo of classified items between front and back
// depends on slfr_pkg

module slfr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  slfr_pkg::q_item_t  push_item,
  input  logic               pop,
  output slfr_pkg::q_item_t  head,
  output slfr_pkg::q_stat_t  q_stat
);

  localparam int PW = (slfr_pkg::QUEUE_DEPTH > 1) ? $clog2(slfr_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(slfr_pkg::QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(slfr_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(slfr_pkg::QUEUE_DEPTH - 1);

  slfr_pkg::q_item_t entries [slfr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full     = (count == DEPTH_C);
  assign q_stat.nonempty = (count != '0);
  assign do_push         = push && !q_stat.full;
  assign do_pop          = pop && q_stat.nonempty;
  assign head            = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_P) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_P) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
    if (do_push) begin
      entries[wptr] <= push_item;
    end
  end

endmodule

>>> hw/rtl/slfr_back.sv
// slfr_back: frame buffer, length check, resync scan/shift and result register
// depends on slfr_pkg; takes items from slfr_queue

module slfr_back #(
  parameter int FRAME_CAP = slfr_pkg::FRAME_CAP_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  slfr_pkg::q_stat_t  q_stat,
  input  slfr_pkg::q_item_t  q_head,
  output logic               q_pop,
  input  logic               cfg_valid,
  input  logic [8:0]         cfg_data,
  output logic               res_valid,
  input  logic               res_stall,
  output slfr_pkg::out_item_t res_item
);

  localparam int AW = $clog2(FRAME_CAP);
  localparam int FW = $clog2(FRAME_CAP + 1);
  localparam logic [FW-1:0] CAP_F  = FW'(FRAME_CAP);
  localparam logic [16:0]   CAP17  = 17'(FRAME_CAP);
  localparam logic [FW-1:0] HDR_F  = FW'(slfr_pkg::HEADER_BYTES);
  localparam logic [16:0]   EXTRA  = 17'(slfr_pkg::LEN_EXTRA);

  typedef enum logic [3:0] {
    B_IDLE, B_WRITE, B_CHECK, B_RDWAIT, B_FIN,
    R_SCAN, R_SHIFT, R_FBRD, R_FBCHK
  } state_t;

  typedef enum logic {
    RET_WRITE,
    RET_FIN
  } ret_t;

  // frame buffer: one write port, two registered read ports
  logic [7:0]    mem [FRAME_CAP];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic [7:0]    rda;
  logic [7:0]    rdb;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rda <= mem[ra];
    rdb <= mem[rb];
  end

  state_t              state, state_next;
  ret_t                ret, ret_next;
  logic [FW-1:0]       fill, fill_next;
  logic [7:0]          len_lo, len_lo_next;
  logic [7:0]          len_hi, len_hi_next;
  slfr_pkg::q_item_t   cur, cur_next;
  logic [2:0]          st, st_next;
  logic [8:0]          flen, flen_next;
  logic [7:0]          rdata, rdata_next;
  logic                resynced, resynced_next;
  logic [FW-1:0]       roff, roff_next;
  logic                cmp_vld, cmp_vld_next;
  logic [FW-1:0]       cmp_off, cmp_off_next;
  logic [FW-1:0]       sh_off, sh_off_next;
  logic [FW-1:0]       sh_src, sh_src_next;
  logic                wr_vld, wr_vld_next;
  logic [AW-1:0]       wr_dst, wr_dst_next;
  logic [8:0]          min_len, min_len_next;
  logic                res_valid_next;
  slfr_pkg::out_item_t res_item_next;
  logic [16:0]         expect_len;
  logic [FW-1:0]       wpos;

  assign expect_len = {len_hi, len_lo} + EXTRA;
  // a full buffer that survived resync is emptied before the store
  assign wpos       = (fill >= CAP_F) ? '0 : fill;

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    fill_next      = fill;
    len_lo_next    = len_lo;
    len_hi_next    = len_hi;
    cur_next       = cur;
    st_next        = st;
    flen_next      = flen;
    rdata_next     = rdata;
    resynced_next  = resynced;
    roff_next      = roff;
    cmp_vld_next   = cmp_vld;
    cmp_off_next   = cmp_off;
    sh_off_next    = sh_off;
    sh_src_next    = sh_src;
    wr_vld_next    = wr_vld;
    wr_dst_next    = wr_dst;
    min_len_next   = cfg_valid ? cfg_data : min_len;
    res_valid_next = res_valid && res_stall;
    res_item_next  = res_item;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    ra             = '0;
    rb             = '0;
    q_pop          = 1'b0;

    case (state)
      B_IDLE: begin
        if (q_stat.nonempty) begin
          q_pop         = 1'b1;
          cur_next      = q_head;
          st_next       = slfr_pkg::ST_COLLECT;
          flen_next     = '0;
          rdata_next    = '0;
          resynced_next = 1'b0;
          if (q_head.op == slfr_pkg::OP_READ) begin
            st_next    = slfr_pkg::ST_READ;
            ra         = AW'(q_head.read_index);
            state_next = B_RDWAIT;
          end else if (fill == '0) begin
            if (q_head.is_sync1) begin
              mem_we    = 1'b1;
              mem_wa    = '0;
              mem_wd    = q_head.rx_byte;
              fill_next = FW'(1);
            end else begin
              st_next = slfr_pkg::ST_HUNT;
            end
            state_next = B_FIN;
          end else if (fill == FW'(1)) begin
            mem_we = 1'b1;
            mem_wd = q_head.rx_byte;
            if (q_head.is_sync2) begin
              mem_wa    = AW'(1);
              fill_next = FW'(2);
            end else begin
              // mismatch replaces the held sync byte
              mem_wa = '0;
              if (q_head.is_sync1) begin
                fill_next = FW'(1);
              end else begin
                fill_next = '0;
                st_next   = slfr_pkg::ST_HUNT;
              end
            end
            state_next = B_FIN;
          end else if (fill >= CAP_F) begin
            resynced_next = 1'b1;
            ret_next      = RET_WRITE;
            roff_next     = FW'(1);
            cmp_vld_next  = 1'b0;
            state_next    = R_SCAN;
          end else begin
            state_next = B_WRITE;
          end
        end
      end

      B_WRITE: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(wpos);
        mem_wd    = cur.rx_byte;
        fill_next = wpos + FW'(1);
        if (wpos == FW'(2)) begin
          len_lo_next = cur.rx_byte;
        end
        if (wpos == FW'(3)) begin
          len_hi_next = cur.rx_byte;
        end
        state_next = B_CHECK;
      end

      B_CHECK: begin
        state_next = B_FIN;
        if (fill >= HDR_F) begin
          if (expect_len < 17'(min_len) || expect_len > CAP17 ||
              17'(fill) > expect_len) begin
            resynced_next = 1'b1;
            ret_next      = RET_FIN;
            roff_next     = FW'(1);
            cmp_vld_next  = 1'b0;
            state_next    = R_SCAN;
          end else if (17'(fill) == expect_len) begin
            st_next   = slfr_pkg::ST_DONE;
            flen_next = expect_len[8:0];
            fill_next = '0;
          end
        end
      end

      B_RDWAIT: begin
        if (32'(cur.read_index) < FRAME_CAP) begin
          rdata_next = rda;
        end
        state_next = B_FIN;
      end

      B_FIN: begin
        if (!res_valid || !res_stall) begin
          res_valid_next             = 1'b1;
          res_item_next.status       = (resynced && st != slfr_pkg::ST_DONE) ?
                                       slfr_pkg::ST_RESYNC : st;
          res_item_next.frame_length = flen;
          res_item_next.read_data    = rdata;
          res_item_next.fill_level   = 9'(fill);
          state_next                 = B_IDLE;
        end
      end

      R_SCAN: begin
        // each pair is read through the registered ports in the cycle before its compare
        if (cmp_vld && rda == slfr_pkg::SYNC_FIRST && rdb == slfr_pkg::SYNC_SECOND) begin
          sh_off_next  = cmp_off;
          sh_src_next  = cmp_off;
          wr_vld_next  = 1'b0;
          cmp_vld_next = 1'b0;
          state_next   = R_SHIFT;
        end else if (roff + FW'(1) < fill) begin
          ra           = AW'(roff);
          rb           = AW'(roff + FW'(1));
          cmp_vld_next = 1'b1;
          cmp_off_next = roff;
          roff_next    = roff + FW'(1);
        end else if (cmp_vld) begin
          cmp_vld_next = 1'b0;
        end else begin
          state_next = R_FBRD;
        end
      end

      R_SHIFT: begin
        if (wr_vld) begin
          mem_we = 1'b1;
          mem_wa = wr_dst;
          mem_wd = rda;
          if (wr_dst == AW'(2)) begin
            len_lo_next = rda;
          end
          if (wr_dst == AW'(3)) begin
            len_hi_next = rda;
          end
        end
        if (sh_src < fill) begin
          ra          = AW'(sh_src);
          wr_vld_next = 1'b1;
          wr_dst_next = AW'(sh_src - sh_off);
          sh_src_next = sh_src + FW'(1);
        end else begin
          wr_vld_next = 1'b0;
          if (!wr_vld) begin
            fill_next  = fill - sh_off;
            state_next = (ret == RET_WRITE) ? B_WRITE : B_FIN;
          end
        end
      end

      R_FBRD: begin
        ra         = AW'(fill - FW'(1));
        state_next = R_FBCHK;
      end

      R_FBCHK: begin
        // keep a trailing sync byte alone, otherwise drop everything
        if (fill != '0 && rda == slfr_pkg::SYNC_FIRST) begin
          mem_we    = 1'b1;
          mem_wa    = '0;
          mem_wd    = slfr_pkg::SYNC_FIRST;
          fill_next = FW'(1);
        end else begin
          fill_next = '0;
        end
        state_next = (ret == RET_WRITE) ? B_WRITE : B_FIN;
      end

      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      fill      <= '0;
      cmp_vld   <= 1'b0;
      wr_vld    <= 1'b0;
      res_valid <= 1'b0;
      min_len   <= slfr_pkg::MIN_LEN_RST;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      cmp_vld   <= cmp_vld_next;
      wr_vld    <= wr_vld_next;
      res_valid <= res_valid_next;
      min_len   <= min_len_next;
    end
    ret      <= ret_next;
    len_lo   <= len_lo_next;
    len_hi   <= len_hi_next;
    cur      <= cur_next;
    st       <= st_next;
    flen     <= flen_next;
    rdata    <= rdata_next;
    resynced <= resynced_next;
    roff     <= roff_next;
    cmp_off  <= cmp_off_next;
    sh_off   <= sh_off_next;
    sh_src   <= sh_src_next;
    wr_dst   <= wr_dst_next;
    res_item <= res_item_next;
  end

endmodule

>>> hw/rtl/slfr_checker.sv
// slfr_checker: port-level checks for sync_length_frame_receiver
// depends on slfr_pkg; attached to the top level by the bind below

module slfr_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_stall,
  input slfr_pkg::out_item_t res_item
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status == slfr_pkg::ST_DONE |-> res_item.fill_level == 9'd0)
    else $error("buffer not emptied on complete frame");

  a_hunt_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status == slfr_pkg::ST_HUNT |-> res_item.fill_level == 9'd0)
    else $error("buffer not empty while hunting");

  a_len_only_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status != slfr_pkg::ST_DONE |-> res_item.frame_length == 9'd0)
    else $error("frame length shown without complete frame");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

>>> tb/tb.sv
// tb: self-checking bench for sync_length_frame_receiver; a predictor class tracks the
// frame buffer, fill count and minimum length and checks every result transfer in order
// depends on slfr_pkg and the sync_length_frame_receiver rtl only

module tb;
  import slfr_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 2 * FRAME_CAP_DEF + 100;
  localparam int RANDOM_ITEMS = 1150;
  localparam int SEGMENTS     = 6;

  class deframe_tracker;
    logic [7:0] byte_store [FRAME_CAP_DEF];
    bit         store_written [FRAME_CAP_DEF];
    int         fill;
    int         min_len;
    int         error_count;
    out_item_t  expected_results [$];

    function new();
      fill = 0;
      min_len = MIN_LEN_RST;
      error_count = 0;
      foreach (store_written[i]) store_written[i] = 1'b0;
    endfunction

    function void set_min_len(logic [8:0] v);
      min_len = v;
    endfunction

    function void put_byte(int pos, logic [7:0] b);
      byte_store[pos] = b;
      store_written[pos] = 1'b1;
    endfunction

    // move a later sync pair to the front, else keep a trailing sync byte or drop all
    function void resync_store();
      int off;
      int i;
      for (off = 1; off + 1 < fill; off++) begin
        if (byte_store[off] == SYNC_FIRST && byte_store[off + 1] == SYNC_SECOND) begin
          for (i = 0; i < fill - off; i++) byte_store[i] = byte_store[i + off];
          fill -= off;
          return;
        end
      end
      if (fill > 0 && byte_store[fill - 1] == SYNC_FIRST) begin
        byte_store[0] = SYNC_FIRST;
        fill = 1;
      end else begin
        fill = 0;
      end
    endfunction

    function out_item_t predict_frame_step(in_item_t it);
      out_item_t r;
      int        total;
      bit        resynced;
      logic [7:0] b;
      r = '0;
      r.status = ST_COLLECT;
      resynced = 1'b0;
      b = it.rx_byte;
      if (op_t'(it.action) == OP_READ) begin
        r.status = ST_READ;
        r.read_data = byte_store[it.read_index];
      end else if (fill == 0) begin
        if (b == SYNC_FIRST) begin
          put_byte(0, b);
          fill = 1;
        end else begin
          r.status = ST_HUNT;
        end
      end else if (fill == 1) begin
        if (b == SYNC_SECOND) begin
          put_byte(1, b);
          fill = 2;
        end else begin
          // a second '9' restarts the hunt with that byte held
          put_byte(0, b);
          fill = (b == SYNC_FIRST) ? 1 : 0;
          if (fill == 0) r.status = ST_HUNT;
        end
      end else begin
        if (fill >= FRAME_CAP_DEF) begin
          resync_store();
          resynced = 1'b1;
        end
        if (fill >= FRAME_CAP_DEF) fill = 0;
        put_byte(fill, b);
        fill++;
        if (fill >= HEADER_BYTES) begin
          total = {byte_store[3], byte_store[2]} + LEN_EXTRA;
          if (total < min_len || total > FRAME_CAP_DEF) begin
            resync_store();
            resynced = 1'b1;
          end else if (fill == total) begin
            r.status = ST_DONE;
            r.frame_length = 9'(total);
            fill = 0;
          end else if (fill > total) begin
            resync_store();
            resynced = 1'b1;
          end
        end
        if (resynced && r.status != ST_DONE) r.status = ST_RESYNC;
      end
      r.fill_level = 9'(fill);
      return r;
    endfunction

    function void note_transfer(in_item_t it);
      expected_results.push_back(predict_frame_step(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer with none expected: status %0d fill_level %0d",
               got.status, got.fill_level);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
        error_count++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
        error_count++;
      end
      if (got.fill_level !== want.fill_level) begin
        $error("fill_level: expected %0d, got %0d", want.fill_level, got.fill_level);
        error_count++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      rx_valid = 1'b0;
  logic      rx_stall;
  in_item_t  rx_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [8:0] cfg_data = '0;

  deframe_tracker track;
  int send_idle = 19;
  int recv_idle = 46;
  int items_sent = 0;
  int cycles = 0;

  always #4 clk = ~clk;

  sync_length_frame_receiver DUT (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_item   (rx_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always @(negedge clk) begin
    res_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) track.check_result(res_item);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL sync_length_frame_receiver");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    @(negedge clk);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_item <= it;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    track.note_transfer(it);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    rx_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (track.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_min_len(logic [8:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    track.set_min_len(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_recv(logic [7:0] b);
    in_item_t it;
    it.action = OP_RECV;
    it.rx_byte = b;
    it.read_index = 8'($urandom_range(255));
    send_item(it);
  endtask

  task automatic send_read(logic [7:0] idx);
    in_item_t it;
    it.action = OP_READ;
    it.rx_byte = 8'($urandom_range(255));
    it.read_index = idx;
    send_item(it);
  endtask

  // biased toward the sync bytes so embedded syncs show up in payloads
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(99);
    if (r < 8) return SYNC_FIRST;
    if (r < 13) return SYNC_SECOND;
    return 8'($urandom_range(255));
  endfunction

  // only entries that were written at some point may be read
  function automatic int pick_read_index(int hi);
    int k;
    int j;
    int start;
    for (k = 0; k < 16; k++) begin
      j = $urandom_range(hi);
      if (track.store_written[j]) return j;
    end
    start = $urandom_range(FRAME_CAP_DEF - 1);
    for (k = 0; k < FRAME_CAP_DEF; k++) begin
      j = (start + k) % FRAME_CAP_DEF;
      if (track.store_written[j]) return j;
    end
    return -1;
  endfunction

  task automatic read_some(int hi, int n);
    int i;
    int idx;
    for (i = 0; i < n; i++) begin
      idx = pick_read_index(hi);
      if (idx >= 0) send_read(8'(idx));
    end
  endtask

  function automatic int pick_total();
    int lo;
    int t;
    lo = (track.min_len > LEN_EXTRA) ? track.min_len : LEN_EXTRA;
    if ($urandom_range(99) < 4) return $urandom_range(FRAME_CAP_DEF, (lo > 128) ? lo : 128);
    t = lo + $urandom_range(14);
    return (t > FRAME_CAP_DEF) ? FRAME_CAP_DEF : t;
  endfunction

  task automatic send_header(int total);
    logic [15:0] len;
    len = 16'(total - LEN_EXTRA);
    send_recv(SYNC_FIRST);
    send_recv(SYNC_SECOND);
    send_recv(len[7:0]);
    send_recv(len[15:8]);
  endtask

  // header plus only part of the payload
  task automatic send_truncated();
    int total;
    int n;
    int i;
    total = pick_total();
    send_header(total);
    n = $urandom_range(total - HEADER_BYTES - 1);
    for (i = 0; i < n; i++) send_recv(rand_byte());
  endtask

  task automatic send_random_chunk();
    int k;
    int n;
    int i;
    int total;
    logic [15:0] len;
    k = $urandom_range(99);
    if (k < 55) begin
      total = pick_total();
      send_header(total);
      for (i = 0; i < total - HEADER_BYTES; i++) send_recv(rand_byte());
      read_some(total - 1, $urandom_range(2));
    end else if (k < 63) begin
      // length field outside the accepted range
      if (track.min_len > LEN_EXTRA && $urandom_range(1))
        len = 16'($urandom_range(track.min_len - LEN_EXTRA - 1));
      else
        len = 16'($urandom_range(16'hFFFF, FRAME_CAP_DEF - LEN_EXTRA + 1));
      send_recv(SYNC_FIRST);
      send_recv(SYNC_SECOND);
      send_recv(len[7:0]);
      send_recv(len[15:8]);
      n = $urandom_range(4);
      for (i = 0; i < n; i++) send_recv(rand_byte());
    end else if (k < 72) begin
      send_truncated();
    end else if (k < 88) begin
      n = $urandom_range(8, 1);
      for (i = 0; i < n; i++) send_recv(rand_byte());
    end else begin
      read_some(FRAME_CAP_DEF - 1, $urandom_range(3, 1));
    end
  endtask

  initial begin
    int seg;
    int cut;
    logic [8:0] min_setting;
    track = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // hunting on noise, mismatch after the first sync byte, a repeated sync byte
    send_recv(8'h00);
    send_recv(8'hFF);
    send_recv(SYNC_FIRST);
    send_recv(8'h41);
    send_recv(SYNC_FIRST);
    send_recv(SYNC_FIRST);
    // shortest frame
    send_recv(SYNC_SECOND);
    send_recv(8'h00);
    send_recv(8'h00);
    send_recv(8'hAA);
    send_recv(8'h55);
    // reads of the finished frame from the emptied buffer
    send_read(8'd0);
    send_read(8'd5);
    send_read(8'd3);
    // length far beyond capacity forces a resync that empties the buffer
    send_recv(SYNC_FIRST);
    send_recv(SYNC_SECOND);
    send_recv(8'hFF);
    send_recv(8'hFF);
    // bad length bytes that are themselves a sync pair get shifted to the front
    send_recv(SYNC_FIRST);
    send_recv(SYNC_SECOND);
    send_recv(SYNC_FIRST);
    send_recv(SYNC_SECOND);
    send_recv(8'h00);
    send_recv(8'h00);
    send_recv(8'h01);
    send_recv(8'h80);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      stop_sending();
      wait_drain();
      case (seg)
        0: min_setting = 9'd0;
        1: min_setting = 9'd40;
        2: min_setting = 9'(FRAME_CAP_DEF);
        3: min_setting = 9'($urandom_range(64, 7));
        4: min_setting = MIN_LEN_RST;
        default: min_setting = 9'($urandom_range(FRAME_CAP_DEF));
      endcase
      write_min_len(min_setting);
      if (seg < 2) begin
        send_idle = 19;
        recv_idle = 46;
      end else if (seg < 4) begin
        send_idle = 46;
        recv_idle = 19;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      cut = RANDOM_ITEMS * (seg + 1) / SEGMENTS;
      while (items_sent < cut) send_random_chunk();
      // leave a frame half collected so the next setting meets a partly filled buffer
      send_truncated();
    end

    stop_sending();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (track.error_count == 0 && track.expected_results.size() == 0) begin
      $display("PASS sync_length_frame_receiver");
    end else begin
      $display("FAIL sync_length_frame_receiver");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/slfr_pkg.sv
hw/rtl/slfr_front.sv
hw/rtl/slfr_queue.sv
hw/rtl/slfr_back.sv
hw/rtl/sync_length_frame_receiver.sv
hw/rtl/slfr_checker.sv
tb/tb.sv
